FILE: rtl/dre_pkg.sv
// Types and constants shared by the row elimination core.
// Depends on nothing.
package dre_pkg;

  localparam int IDX_W    = 12;
  localparam int VAL_W    = 32;
  localparam int ROWCNT_W = 13;

  localparam logic [ROWCNT_W-1:0] ROWCNT_RST = 13'd4096;

  localparam logic [2:0] ACT_MARK  = 3'd0;
  localparam logic [2:0] ACT_BEGIN = 3'd1;
  localparam logic [2:0] ACT_ENTRY = 3'd2;
  localparam logic [2:0] ACT_END   = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NODIAG = 2'd2;

  localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sh0001_0000;

  typedef struct packed {
    logic [2:0]              action;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [1:0]              status;
  } out_beat_t;

  // item after the table read and the multiply
  typedef struct packed {
    logic                      valid;
    logic [2:0]                action;
    logic signed [VAL_W-1:0]   value;
    logic                      diag_hit;
    logic                      range_err;
    logic                      marked;
    logic                      row_ok;
    logic signed [VAL_W-1:0]   pvalue;
    logic signed [2*VAL_W-1:0] product;
  } s2_beat_t;

endpackage

FILE: rtl/dirichlet_row_elimination_core.sv
// Prescribed-value row elimination on a CSR row stream; one result beat per input beat.
// Pipeline: table read with s1, then s2, then the dre_update result register. Throughput: one beat
// per cycle while out_ready and no clearing pass stall it. Marks live in a 1-bit table of
// min(MAX_ROWS,4096) entries; reset and each clear-marks beat run a clearing pass over every entry
// with in_ready low. Reset is synchronous, active low. Depends on dre_pkg, dre_ram, dre_update.
module dirichlet_row_elimination_core #(
  parameter int MAX_ROWS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dre_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dre_pkg::out_beat_t            out_data,
  input  logic                          cfg_wr_en,
  input  logic [dre_pkg::ROWCNT_W-1:0]  cfg_wr_data
);

  localparam int DEPTH = (MAX_ROWS < 4096) ? MAX_ROWS : 4096;
  localparam int AW    = $clog2(DEPTH);

  logic                              en;
  logic                              acc;
  logic                              idx_ok;
  logic                              mark_ok;
  logic                              is_end;
  logic [AW-1:0]                     issue_addr;
  logic [dre_pkg::ROWCNT_W-1:0]      row_count_r;
  logic [dre_pkg::IDX_W-1:0]         current_row_r;
  logic                              cur_row_ok_r;
  logic                              sweep_r;
  logic [AW-1:0]                     sweep_addr_r;
  logic                              mark_q;
  logic [dre_pkg::VAL_W-1:0]         val_q;

  logic                              s1_valid_r;
  logic [2:0]                        s1_action_r;
  logic signed [dre_pkg::VAL_W-1:0]  s1_value_r;
  logic                              s1_diag_r;
  logic                              s1_rerr_r;
  logic                              s1_rng_r;
  dre_pkg::s2_beat_t                 s2_r;

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !sweep_r;
  assign acc      = in_valid && in_ready;

  assign idx_ok  = 32'(in_data.index) < MAX_ROWS;
  assign mark_ok = (in_data.action == dre_pkg::ACT_MARK) && idx_ok
                && ({1'b0, in_data.index} < row_count_r);
  assign is_end  = in_data.action == dre_pkg::ACT_END;
  assign issue_addr = is_end ? current_row_r[AW-1:0] : in_data.index[AW-1:0];

  dre_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mark_ram (
    .clk   (clk),
    .en    (acc || sweep_r),
    .we    (sweep_r || mark_ok),
    .addr  (sweep_r ? sweep_addr_r : issue_addr),
    .wdata (!sweep_r),
    .rdata (mark_q)
  );

  dre_ram #(.WIDTH(dre_pkg::VAL_W), .DEPTH(DEPTH)) u_value_ram (
    .clk   (clk),
    .en    (acc),
    .we    (mark_ok),
    .addr  (issue_addr),
    .wdata (in_data.value),
    .rdata (val_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= dre_pkg::ROWCNT_RST;
      current_row_r <= '0;
      cur_row_ok_r  <= 1'b1;
      sweep_r       <= 1'b1;
      sweep_addr_r  <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        row_count_r <= cfg_wr_data;
      end
      if (acc && in_data.action == dre_pkg::ACT_BEGIN) begin
        current_row_r <= in_data.index;
        cur_row_ok_r  <= idx_ok;
      end
      if (sweep_r) begin
        sweep_addr_r <= sweep_addr_r + 1'b1;
        if (sweep_addr_r == AW'(DEPTH - 1)) begin
          sweep_r <= 1'b0;
        end
      end else if (acc && in_data.action == dre_pkg::ACT_CLEAR) begin
        sweep_r      <= 1'b1;
        sweep_addr_r <= '0;
      end
      if (en) begin
        s1_valid_r <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_action_r <= in_data.action;
      s1_value_r  <= in_data.value;
      s1_diag_r   <= in_data.index == current_row_r;
      s1_rerr_r   <= (in_data.action == dre_pkg::ACT_MARK) && !mark_ok;
      s1_rng_r    <= is_end ? cur_row_ok_r : idx_ok;
    end
    if (en) begin
      s2_r.action    <= s1_action_r;
      s2_r.value     <= s1_value_r;
      s2_r.diag_hit  <= s1_diag_r;
      s2_r.range_err <= s1_rerr_r;
      s2_r.marked    <= s1_rng_r && mark_q;
      s2_r.row_ok    <= s1_rng_r;
      s2_r.pvalue    <= $signed(val_q);
      s2_r.product   <= s1_value_r * $signed(val_q);
    end
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (en) begin
      s2_r.valid <= s1_valid_r;
    end
  end

  dre_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .s2        (s2_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/dre_ram.sv
// Single-port synchronous RAM, registered read data.
// Depends on nothing.
module dre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/dre_update.sv
// Row state update, rhs subtract of the product with round and saturate, result register.
// Depends on dre_pkg.
module dre_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  dre_pkg::s2_beat_t   s2,
  output logic                out_valid,
  output dre_pkg::out_beat_t  out_data
);

  logic                              out_valid_r;
  dre_pkg::out_beat_t                out_data_r;
  dre_pkg::out_beat_t                out_data_nxt;
  logic signed [dre_pkg::VAL_W-1:0]  rhs_r, rhs_nxt;
  logic                              rc_r, rc_nxt;
  logic                              ds_r, ds_nxt;
  logic signed [2*dre_pkg::VAL_W:0]  wide;
  logic signed [dre_pkg::VAL_W-1:0]  sub_res;

  // rhs*2^16 - a*p + 0.5, then floor by 2^16 and saturate
  always_comb begin
    wide = $signed({{17{rhs_r[31]}}, rhs_r, 16'h0000})
         - $signed({s2.product[63], s2.product})
         + 65'sh8000;
    if (wide[64:47] == {18{wide[64]}}) begin
      sub_res = wide[47:16];
    end else if (wide[64]) begin
      sub_res = 32'sh8000_0000;
    end else begin
      sub_res = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    rhs_nxt = rhs_r;
    rc_nxt  = rc_r;
    ds_nxt  = ds_r;
    out_data_nxt.value_out = '0;
    out_data_nxt.status    = dre_pkg::ST_OK;
    case (s2.action)
      dre_pkg::ACT_MARK: begin
        if (s2.range_err) begin
          out_data_nxt.status = dre_pkg::ST_RANGE;
        end
      end
      dre_pkg::ACT_BEGIN: begin
        rhs_nxt = s2.value;
        rc_nxt  = s2.marked;
        ds_nxt  = 1'b0;
      end
      dre_pkg::ACT_ENTRY: begin
        if (rc_r) begin
          if (s2.diag_hit) begin
            out_data_nxt.value_out = dre_pkg::ONE_Q16;
            ds_nxt = 1'b1;
          end
        end else if (s2.marked) begin
          rhs_nxt = sub_res;
        end else begin
          out_data_nxt.value_out = s2.value;
        end
      end
      dre_pkg::ACT_END: begin
        if (rc_r) begin
          if (s2.row_ok) begin
            rhs_nxt = s2.pvalue;
          end
          if (!ds_r) begin
            out_data_nxt.status = dre_pkg::ST_NODIAG;
          end
        end
        out_data_nxt.value_out = rhs_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rhs_r       <= '0;
      rc_r        <= 1'b0;
      ds_r        <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2.valid;
      if (s2.valid) begin
        rhs_r <= rhs_nxt;
        rc_r  <= rc_nxt;
        ds_r  <= ds_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: verif/dre_elim_checker.sv
// Scoreboard for dirichlet_row_elimination_core: keeps its own marks, prescribed values and row
// state, predicts one result beat per accepted input beat and compares them in order.
// Depends on dre_pkg.
module dre_elim_checker
  import dre_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_beat_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_beat_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [ROWCNT_W-1:0] cfg_wr_data,
  output int                  mismatches,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     TABLE_DEPTH = 4096;
  localparam longint SAT_HI      = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO      = -SAT_HI - 1;

  bit                      mark_tbl [TABLE_DEPTH];
  logic signed [VAL_W-1:0] pval_tbl [TABLE_DEPTH];
  logic [IDX_W-1:0]        row_idx;
  logic signed [VAL_W-1:0] rhs_acc;
  logic                    row_fixed;
  logic                    diag_hit;
  logic [ROWCNT_W-1:0]     n_rows;
  out_beat_t               expected_q [$];

  // rhs - a*p in Q16.16, round half up, saturate
  function automatic logic signed [VAL_W-1:0] subtract_scaled(
    input logic signed [VAL_W-1:0] rhs,
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] p
  );
    longint w;
    longint r;
    w = longint'(rhs) * 65536 - longint'(a) * longint'(p);
    r = (w + 32768) >>> 16;
    if (r > SAT_HI) r = SAT_HI;
    else if (r < SAT_LO) r = SAT_LO;
    return r[VAL_W-1:0];
  endfunction

  function automatic out_beat_t eliminate_beat(input in_beat_t b);
    out_beat_t r;
    r.value_out = '0;
    r.status    = ST_OK;
    case (b.action)
      ACT_MARK: begin
        if ({1'b0, b.index} >= n_rows) begin
          r.status = ST_RANGE;
        end else begin
          mark_tbl[b.index] = 1'b1;
          pval_tbl[b.index] = b.value;
        end
      end
      ACT_BEGIN: begin
        row_idx   = b.index;
        rhs_acc   = b.value;
        row_fixed = mark_tbl[b.index];
        diag_hit  = 1'b0;
      end
      ACT_ENTRY: begin
        if (row_fixed) begin
          if (b.index == row_idx) begin
            r.value_out = ONE_Q16;
            diag_hit    = 1'b1;
          end
        end else if (mark_tbl[b.index]) begin
          rhs_acc = subtract_scaled(rhs_acc, b.value, pval_tbl[b.index]);
        end else begin
          r.value_out = b.value;
        end
      end
      ACT_END: begin
        if (row_fixed) begin
          rhs_acc = pval_tbl[row_idx];
          if (!diag_hit) r.status = ST_NODIAG;
        end
        r.value_out = rhs_acc;
      end
      ACT_CLEAR: begin
        foreach (mark_tbl[i]) mark_tbl[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t dre_elim_checker: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      foreach (mark_tbl[i]) mark_tbl[i] = 1'b0;
      row_idx    = '0;
      rhs_acc    = '0;
      row_fixed  = 1'b0;
      diag_hit   = 1'b0;
      n_rows     = ROWCNT_RST;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("unexpected result beat, value_out", out_data.value_out, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.value_out !== want.value_out)
            flag_mismatch("value_out", out_data.value_out, want.value_out);
          if (out_data.status !== want.status)
            flag_mismatch("status", 32'(out_data.status), 32'(want.status));
        end
      end
      if (in_valid && in_ready) expected_q = {expected_q, eliminate_beat(in_data)};
      if (cfg_wr_en) n_rows = cfg_wr_data;
    end
    pending <= expected_q.size();
  end

endmodule

FILE: verif/dirichlet_row_elimination_core_tb.sv
// Top of the dirichlet_row_elimination_core testbench: clock, reset, row_count settings and
// mark/row/clear beat stimulus with random gaps and stalls. Depends on dre_pkg, dre_elim_checker.
module dirichlet_row_elimination_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dre_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_BEATS = 250;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  in_beat_t            in_data     = '0;
  logic                out_ready   = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic [ROWCNT_W-1:0] cfg_wr_data = '0;
  logic                in_ready;
  logic                out_valid;
  out_beat_t           out_data;
  int                  mismatches;
  int                  pending;

  bit source_gaps;
  bit sink_stalls;
  int stall_left;
  int quiet_cycles;
  int row_limit = 4096;
  int random_beats;
  int beats_sent;
  int rows_done;
  int clears_done;
  int settings_done;

  dirichlet_row_elimination_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  dre_elim_checker elim_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("dirichlet_row_elimination_core_tb: FAIL");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'sh7FFF_FFFF;
      1: v = 32'sh8000_0000;
      2, 3: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0008_0000);
        v = v - 32'sh0004_0000;
      end
    endcase
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int pool;
    int v;
    pool = (row_limit < 16) ? row_limit : 16;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: v = row_limit - 1 + $urandom_range(0, 1);
      2: v = row_limit - 1 - $urandom_range(0, pool - 1);
      default: v = $urandom_range(0, pool - 1);
    endcase
    return v[IDX_W-1:0];
  endfunction

  task automatic push_beat(input logic [2:0] act, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val);
    in_beat_t b;
    b.action = act;
    b.index  = idx;
    b.value  = val;
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (act == ACT_CLEAR) clears_done++;
  endtask

  // drain, let the pipeline settle, then write row_count
  task automatic set_row_count(input int rows);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rows[ROWCNT_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    row_limit = rows;
    settings_done++;
  endtask

  task automatic stream_row();
    logic [IDX_W-1:0] r;
    int n;
    bit with_diag;
    r = pick_index();
    n = $urandom_range(0, 5);
    with_diag = $urandom_range(0, 4) != 0;
    push_beat(ACT_BEGIN, r, pick_value());
    for (int k = 0; k < n; k++)
      push_beat(ACT_ENTRY, (with_diag && k == n / 2) ? r : pick_index(), pick_value());
    push_beat(ACT_END, IDX_W'($urandom), $urandom);
    random_beats += n + 2;
    rows_done++;
  endtask

  task automatic run_phase(input int quota, input bit calm);
    int start;
    int n;
    logic [2:0] act;
    start = random_beats;
    source_gaps = !calm;
    sink_stalls = !calm;
    while (random_beats - start < quota) begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        source_gaps = 1'($urandom_range(0, 1));
        sink_stalls = 1'($urandom_range(0, 1));
      end
      case ($urandom_range(0, 39))
        0: begin
          push_beat(ACT_CLEAR, IDX_W'($urandom), $urandom);
          random_beats++;
        end
        1, 2, 3: begin
          act = 3'($urandom_range(0, 7));
          push_beat(act, IDX_W'($urandom), $urandom);
          if (act <= ACT_CLEAR && act != ACT_CLEAR) random_beats++;
        end
        4, 5, 6, 7, 8, 9, 10, 11: begin
          n = $urandom_range(1, 4);
          repeat (n) push_beat(ACT_MARK, pick_index(), pick_value());
          random_beats += n;
        end
        default: stream_row();
      endcase
    end
  endtask

  initial begin
    int settings [5];
    settings = '{4096, 1, 12, 0, 4095};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    set_row_count(8);
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    push_beat(ACT_MARK, 12'd8, 32'sh0001_0000);
    push_beat(ACT_MARK, 12'd4095, 32'sh0000_0001);
    push_beat(ACT_MARK, 12'd0, 32'sh8000_0000);
    push_beat(ACT_MARK, 12'd7, 32'sh7FFF_FFFF);
    push_beat(ACT_MARK, 12'd3, 32'sh0001_8000);
    push_beat(ACT_MARK, 12'd2, 32'sh0000_8000);
    push_beat(ACT_BEGIN, 12'd3, 32'sh0005_0000);
    push_beat(ACT_ENTRY, 12'd3, 32'sh1234_5678);
    push_beat(ACT_ENTRY, 12'd5, 32'sh0002_0000);
    push_beat(ACT_END, 12'd0, 32'sh0000_0000);
    push_beat(ACT_BEGIN, 12'd7, 32'sh0000_0000);
    push_beat(ACT_ENTRY, 12'd6, 32'sh0001_0000);
    push_beat(ACT_END, 12'd0, 32'sh0000_0000);
    push_beat(ACT_BEGIN, 12'd1, 32'sh7FFF_FFFF);
    push_beat(ACT_ENTRY, 12'd0, 32'sh8000_0000);
    push_beat(ACT_ENTRY, 12'd7, 32'sh8000_0000);
    push_beat(ACT_ENTRY, 12'd2, 32'sh0000_0001);
    push_beat(ACT_ENTRY, 12'd2, -32'sh0000_0001);
    push_beat(ACT_ENTRY, 12'd4095, 32'sh8000_0000);
    push_beat(ACT_END, 12'd0, 32'sh0000_0000);
    push_beat(ACT_ENTRY, 12'd2, 32'shFFFF_FFFF);
    push_beat(3'd5, 12'hFFF, 32'shFFFF_FFFF);
    push_beat(ACT_CLEAR, 12'd0, 32'sh0000_0000);
    push_beat(ACT_BEGIN, 12'd3, 32'sh0003_0000);
    push_beat(ACT_ENTRY, 12'd3, 32'sh0001_0000);
    push_beat(ACT_END, 12'd0, 32'sh0000_0000);

    foreach (settings[i]) begin
      set_row_count(settings[i] == 0 ? $urandom_range(2, 4094) : settings[i]);
      run_phase(PHASE_BEATS, i == $size(settings) - 1);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d beats: %0d rows, %0d clear-marks passes, across %0d row_count settings",
             beats_sent, rows_done, clears_done, settings_done);
    $display("(row_count 1 to 4096, saturation, rounding ties, missing diagonals, range errors).");
    if (mismatches == 0 && pending == 0) begin
      $display("dirichlet_row_elimination_core_tb: PASS");
    end else begin
      $display("dirichlet_row_elimination_core_tb: FAIL");
    end
    $finish;
  end

endmodule
